### src/htsd_pkg.sv
// Shared types and constants for the Huffman tree stream decoder.
// No dependencies; every other file imports this package.
package htsd_pkg;

    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int NODE_DEPTH  = 511;
    localparam int STACK_DEPTH = 256;
    localparam int IDX_W       = 9;
    localparam int FIELD_W     = 19;
    localparam int SP_W        = 8;
    localparam int LEVEL_W     = 9;
    localparam int COUNT_W     = 10;
    localparam int PEND_W      = 10;
    localparam int LEAF_BIT    = 18;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_HASH = 8'h23;

    localparam logic STATUS_SYMBOL = 1'b0;
    localparam logic STATUS_ERROR  = 1'b1;

    typedef struct packed {
        logic       push;
        logic [7:0] symbol;
        logic       status;
        logic       last;
    } out_push_t;

endpackage

### src/huffman_tree_stream_decoder.sv
// Top level of the Huffman tree stream decoder: control sequencer, node table
// and parent stack memories. Depends on htsd_pkg and htsd_out_stage.
//
// One byte is taken at a time. A payload byte takes one read of the node table
// per bit, issued back to back through its single read port unless the output
// stalls, and a flush of the last symbol. A header byte that builds a node may
// go through the read-modify-write of the parent entry and the parent stack; a
// '1' tag, the '#' byte and ignored bytes are taken in the idle state alone, an
// error passes through the error state. There is no clearing pass after reset.
module huffman_tree_stream_decoder #(
    parameter int ALPHABET_SIZE = htsd_pkg::ALPHABET_SIZE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_start_of_file,
    input  logic [7:0] s_byte_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_symbol,
    output logic       m_status,
    output logic       m_last_of_run
);
    import htsd_pkg::*;

    localparam int NODE_LIMIT = (2 * ALPHABET_SIZE - 1 > NODE_DEPTH) ?
                                NODE_DEPTH : 2 * ALPHABET_SIZE - 1;

    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_SYM     = 3'd1;
    localparam logic [2:0] PH_HASH    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;
    localparam logic [2:0] PH_SILENT  = 3'd5;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_TOP     = 3'd1;
    localparam logic [2:0] S_MOD     = 3'd2;
    localparam logic [2:0] S_PUSH    = 3'd3;
    localparam logic [2:0] S_LEAFEND = 3'd4;
    localparam logic [2:0] S_WALK    = 3'd5;
    localparam logic [2:0] S_FLUSH   = 3'd6;
    localparam logic [2:0] S_ERR     = 3'd7;

    logic [FIELD_W-1:0] node_mem [NODE_DEPTH];
    logic [PEND_W-1:0]  stack_mem [STACK_DEPTH];

    logic [2:0]         state_reg, state_next;
    logic [2:0]         phase_reg, phase_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [COUNT_W-1:0] nodes_reg, nodes_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               inner_reg, inner_next;
    logic [PEND_W-1:0]  top_reg, top_next;
    logic [7:0]         byte_reg, byte_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [FIELD_W-1:0] cur_reg, cur_next;
    logic [FIELD_W-1:0] root_reg;
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_sym_reg, pend_sym_next;

    logic               n_we, n_re;
    logic [IDX_W-1:0]   n_waddr, n_raddr;
    logic [FIELD_W-1:0] n_wdata, n_rdata;
    logic               k_we, k_re;
    logic [SP_W-1:0]    k_waddr, k_raddr;
    logic [PEND_W-1:0]  k_wdata, k_rdata;

    out_push_t          push;
    logic               out_free;

    logic               accept;
    logic [2:0]         ph_eff;
    logic [LEVEL_W-1:0] level_eff;
    logic [COUNT_W-1:0] nodes_eff;
    logic               full_nodes;
    logic [FIELD_W-1:0] base;

    function automatic logic [IDX_W-1:0] child(input logic [FIELD_W-1:0] f, input logic b);
        logic [IDX_W-1:0] c;
        c = b ? f[IDX_W-1:0] : f[2*IDX_W-1:IDX_W];
        return (c >= IDX_W'(NODE_DEPTH)) ? '0 : c;
    endfunction

    always_ff @(posedge aclk) begin
        if (n_we) begin
            node_mem[n_waddr] <= n_wdata;
        end
        if (n_re) begin
            n_rdata <= node_mem[n_raddr];
        end
        if (n_we && n_waddr == '0) begin
            root_reg <= n_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (k_we) begin
            stack_mem[k_waddr] <= k_wdata;
        end
        if (k_re) begin
            k_rdata <= stack_mem[k_raddr];
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign ph_eff     = s_start_of_file ? PH_TAG : phase_reg;
    assign level_eff  = s_start_of_file ? '0 : level_reg;
    assign nodes_eff  = s_start_of_file ? '0 : nodes_reg;
    assign full_nodes = nodes_eff >= COUNT_W'(NODE_LIMIT);
    assign base       = n_rdata[LEAF_BIT] ? root_reg : n_rdata;

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        level_next      = level_reg;
        nodes_next      = nodes_reg;
        idx_next        = idx_reg;
        inner_next      = inner_reg;
        top_next        = top_reg;
        byte_next       = byte_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        n_we = 1'b0; n_waddr = '0; n_wdata = '0;
        n_re = 1'b0; n_raddr = '0;
        k_we = 1'b0; k_waddr = '0; k_wdata = '0;
        k_re = 1'b0; k_raddr = '0;
        push = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    phase_next = ph_eff;
                    level_next = level_eff;
                    nodes_next = nodes_eff;
                    case (ph_eff)
                        PH_TAG, PH_SYM: begin
                            if (ph_eff == PH_TAG && s_byte_value == CH_ONE) begin
                                phase_next = PH_SYM;
                            end else if (ph_eff == PH_TAG && s_byte_value != CH_ZERO) begin
                                state_next = S_ERR;
                            end else if (full_nodes ||
                                         (ph_eff == PH_TAG &&
                                          level_eff >= LEVEL_W'(STACK_DEPTH))) begin
                                state_next = S_ERR;
                            end else begin
                                inner_next = (ph_eff == PH_TAG);
                                idx_next   = nodes_eff[IDX_W-1:0];
                                nodes_next = nodes_eff + 1'b1;
                                n_we       = 1'b1;
                                n_waddr    = nodes_eff[IDX_W-1:0];
                                n_wdata    = (ph_eff == PH_TAG) ? '0 :
                                             {1'b1, 10'd0, s_byte_value};
                                if (nodes_eff != '0 && level_eff != '0) begin
                                    k_re       = 1'b1;
                                    k_raddr    = SP_W'(level_eff - 1'b1);
                                    state_next = S_TOP;
                                end else begin
                                    state_next = (ph_eff == PH_TAG) ? S_PUSH : S_LEAFEND;
                                end
                            end
                        end
                        PH_HASH: begin
                            if (s_byte_value != CH_HASH) begin
                                state_next = S_ERR;
                            end else begin
                                cur_next   = root_reg;
                                phase_next = root_reg[LEAF_BIT] ? PH_SILENT : PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD: begin
                            byte_next  = s_byte_value;
                            cnt_next   = 3'd7;
                            n_re       = 1'b1;
                            n_raddr    = child(cur_reg, s_byte_value[7]);
                            state_next = S_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TOP: begin
                top_next = k_rdata;
                if (k_rdata[IDX_W-1:0] >= IDX_W'(NODE_DEPTH)) begin
                    state_next = inner_reg ? S_PUSH : S_LEAFEND;
                end else begin
                    n_re       = 1'b1;
                    n_raddr    = k_rdata[IDX_W-1:0];
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                n_we    = 1'b1;
                n_waddr = top_reg[IDX_W-1:0];
                if (!top_reg[IDX_W]) begin
                    n_wdata = {n_rdata[LEAF_BIT], idx_reg, n_rdata[IDX_W-1:0]};
                    k_we    = 1'b1;
                    k_waddr = SP_W'(level_reg - 1'b1);
                    k_wdata = top_reg | PEND_W'(1 << IDX_W);
                end else begin
                    n_wdata    = {n_rdata[LEAF_BIT:IDX_W], idx_reg};
                    level_next = level_reg - 1'b1;
                end
                state_next = inner_reg ? S_PUSH : S_LEAFEND;
            end
            S_PUSH: begin
                k_we       = 1'b1;
                k_waddr    = level_reg[SP_W-1:0];
                k_wdata    = {1'b0, idx_reg};
                level_next = level_reg + 1'b1;
                state_next = S_IDLE;
            end
            S_LEAFEND: begin
                phase_next = (level_reg == '0) ? PH_HASH : PH_TAG;
                state_next = S_IDLE;
            end
            S_WALK: begin
                if (!(n_rdata[LEAF_BIT] && pend_valid_reg && !out_free)) begin
                    if (n_rdata[LEAF_BIT]) begin
                        push.push       = pend_valid_reg;
                        push.symbol     = pend_sym_reg;
                        push.status     = STATUS_SYMBOL;
                        pend_valid_next = 1'b1;
                        pend_sym_next   = n_rdata[7:0];
                    end
                    cur_next = base;
                    if (cnt_reg == '0) begin
                        state_next = S_FLUSH;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                        n_re     = 1'b1;
                        n_raddr  = child(base, byte_reg[cnt_reg - 1'b1]);
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    push.push       = 1'b1;
                    push.symbol     = pend_sym_reg;
                    push.status     = STATUS_SYMBOL;
                    push.last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    push.push   = 1'b1;
                    push.symbol = '0;
                    push.status = STATUS_ERROR;
                    push.last   = 1'b1;
                    phase_next  = PH_ERROR;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_TAG;
            level_reg      <= '0;
            nodes_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            level_reg      <= level_next;
            nodes_reg      <= nodes_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        inner_reg    <= inner_next;
        top_reg      <= top_next;
        byte_reg     <= byte_next;
        cnt_reg      <= cnt_next;
        cur_reg      <= cur_next;
        pend_sym_reg <= pend_sym_next;
    end

    htsd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push_in       (push),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_W'(STACK_DEPTH))
        else $error("Parent stack level exceeds its depth.");

    a_nodes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_reg <= COUNT_W'(NODE_LIMIT))
        else $error("Node count exceeds the node limit.");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push |-> out_free)
        else $error("Result pushed while the output register is occupied.");

    a_busy_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != S_IDLE || phase_reg != PH_PAYLOAD || !$past(ph_eff == PH_PAYLOAD))
        else $error("Payload item finished without walking the tree.");

endmodule

### src/htsd_out_stage.sv
// Output register of the decoder result channel.
// Depends on htsd_pkg for the push request struct.
module htsd_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  htsd_pkg::out_push_t push_in,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_symbol,
    output logic               m_status,
    output logic               m_last_of_run
);
    import htsd_pkg::*;

    logic       valid_reg;
    logic [7:0] symbol_reg;
    logic       status_reg;
    logic       last_reg;

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push_in.push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.push) begin
            symbol_reg <= push_in.symbol;
            status_reg <= push_in.status;
            last_reg   <= push_in.last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_symbol      = symbol_reg;
    assign m_status      = status_reg;
    assign m_last_of_run = last_reg;

endmodule
